FILE: hdl/hxt_pkg.sv
// Shared types and constants for the hextile tile decoder.
package hxt_pkg;

   localparam int BYTES_PER_PIXEL = 4;
   localparam int TILE_SIZE       = 16;
   localparam int BYTE_IDX_W      = 2;
   localparam int PIXEL_W         = 32;

   // Request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Result kinds
   localparam logic KIND_FILL  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Subencoding flag bit positions
   localparam int FLAG_RAW    = 0;
   localparam int FLAG_BG     = 1;
   localparam int FLAG_FG     = 2;
   localparam int FLAG_NSUB   = 3;
   localparam int FLAG_SCOLOR = 4;

   typedef struct packed {
      logic        opcode;
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic [4:0]         fill_width;
      logic [4:0]         fill_height;
      logic [PIXEL_W-1:0] color;
      logic               rect_done;
   } rsp_type;

endpackage

FILE: hdl/hxt_in_stage.sv
// Input register stage: holds one request transaction until the core consumes it.
module hxt_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hxt_pkg::req_type req_data,
   input  logic            step,
   output logic            item_valid,
   output hxt_pkg::req_type item
);

   logic            valid_ff;
   hxt_pkg::req_type data_ff;

   assign req_ready  = !valid_ff || step;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

FILE: hdl/hxt_core.sv
// Hextile parser: tile walker, header sequencer and pixel assembly for one byte per step.
module hxt_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  hxt_pkg::req_type item,
   output logic             res_valid,
   output hxt_pkg::rsp_type res
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SUBENC,
      PH_BG,
      PH_FG,
      PH_NSUB,
      PH_SCOLOR,
      PH_SXY,
      PH_SWH,
      PH_RAW
   } phase_type;

   // Header positions from which the optional parts are searched
   localparam logic [1:0] STAGE_BG   = 2'd0;
   localparam logic [1:0] STAGE_FG   = 2'd1;
   localparam logic [1:0] STAGE_NSUB = 2'd2;

   localparam logic [hxt_pkg::BYTE_IDX_W-1:0] LAST_BYTE =
      hxt_pkg::BYTE_IDX_W'(hxt_pkg::BYTES_PER_PIXEL - 1);

   phase_type                    phase_ff, phase_in;
   logic [15:0]                  origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [15:0]                  rect_w_ff, rect_w_in, rect_h_ff, rect_h_in;
   logic [15:0]                  off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [4:0]                   tile_w_ff, tile_w_in, tile_h_ff, tile_h_in;
   logic [4:0]                   flags_ff, flags_in;
   logic [hxt_pkg::PIXEL_W-1:0]  background_ff, background_in;
   logic [hxt_pkg::PIXEL_W-1:0]  foreground_ff, foreground_in;
   logic [hxt_pkg::PIXEL_W-1:0]  shift_ff, shift_in;
   logic [hxt_pkg::BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [7:0]                   subrects_ff, subrects_in;
   logic [7:0]                   subrect_pos_ff, subrect_pos_in;
   logic [3:0]                   raw_col_ff, raw_col_in, raw_row_ff, raw_row_in;

   logic [15:0]                  tile_x, tile_y;
   logic [15:0]                  next_off_x, next_off_y;
   logic                         more_cols, more_rows;
   logic [hxt_pkg::PIXEL_W-1:0]  shift_new;
   logic                         pix_done;
   logic                         do_finish;
   phase_type                    hdr;

   function automatic logic [4:0] tile_span(input logic [15:0] total, input logic [15:0] off);
      logic [15:0] rem;
      rem = total - off;
      tile_span = (rem < 16'(hxt_pkg::TILE_SIZE)) ? rem[4:0] : 5'(hxt_pkg::TILE_SIZE);
   endfunction

   // PH_IDLE means no header part remains: the background fill goes out now
   function automatic phase_type header_phase(input logic [4:0] flags, input logic [1:0] stage);
      priority if (stage == STAGE_BG && flags[hxt_pkg::FLAG_BG]) begin
         header_phase = PH_BG;
      end else if (stage != STAGE_NSUB && flags[hxt_pkg::FLAG_FG]) begin
         header_phase = PH_FG;
      end else if (flags[hxt_pkg::FLAG_NSUB]) begin
         header_phase = PH_NSUB;
      end else begin
         header_phase = PH_IDLE;
      end
   endfunction

   assign tile_x = origin_x_ff + off_x_ff;
   assign tile_y = origin_y_ff + off_y_ff;

   assign next_off_x = off_x_ff + 16'(hxt_pkg::TILE_SIZE);
   assign next_off_y = off_y_ff + 16'(hxt_pkg::TILE_SIZE);
   assign more_cols  = ({1'b0, off_x_ff} + 17'(hxt_pkg::TILE_SIZE)) < {1'b0, rect_w_ff};
   assign more_rows  = ({1'b0, off_y_ff} + 17'(hxt_pkg::TILE_SIZE)) < {1'b0, rect_h_ff};

   assign shift_new = shift_ff |
                      (hxt_pkg::PIXEL_W'(item.data_byte) << {byte_idx_ff, 3'b000});
   assign pix_done  = (byte_idx_ff == LAST_BYTE);

   always_comb begin
      phase_in       = phase_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      rect_w_in      = rect_w_ff;
      rect_h_in      = rect_h_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      tile_w_in      = tile_w_ff;
      tile_h_in      = tile_h_ff;
      flags_in       = flags_ff;
      background_in  = background_ff;
      foreground_in  = foreground_ff;
      shift_in       = shift_ff;
      byte_idx_in    = byte_idx_ff;
      subrects_in    = subrects_ff;
      subrect_pos_in = subrect_pos_ff;
      raw_col_in     = raw_col_ff;
      raw_row_in     = raw_row_ff;
      do_finish      = 1'b0;
      hdr            = PH_IDLE;

      res_valid       = 1'b0;
      res.kind        = hxt_pkg::KIND_FILL;
      res.pos_x       = tile_x;
      res.pos_y       = tile_y;
      res.fill_width  = tile_w_ff;
      res.fill_height = tile_h_ff;
      res.color       = background_ff;
      res.rect_done   = 1'b0;

      if (item.opcode == hxt_pkg::OP_START) begin
         origin_x_in = item.rect_x;
         origin_y_in = item.rect_y;
         rect_w_in   = item.rect_width;
         rect_h_in   = item.rect_height;
         off_x_in    = '0;
         off_y_in    = '0;
         tile_w_in   = tile_span(item.rect_width, 16'd0);
         tile_h_in   = tile_span(item.rect_height, 16'd0);
         shift_in    = '0;
         byte_idx_in = '0;
         phase_in    = (item.rect_width == 16'd0 || item.rect_height == 16'd0) ?
                       PH_IDLE : PH_SUBENC;
      end else begin
         unique case (phase_ff)
            PH_SUBENC: begin
               flags_in = item.data_byte[4:0];
               if (item.data_byte[hxt_pkg::FLAG_RAW]) begin
                  raw_col_in = '0;
                  raw_row_in = '0;
                  phase_in   = PH_RAW;
               end else begin
                  hdr = header_phase(item.data_byte[4:0], STAGE_BG);
                  if (hdr == PH_IDLE) begin
                     res_valid = 1'b1;
                     do_finish = 1'b1;
                  end else begin
                     phase_in = hdr;
                  end
               end
            end
            PH_BG, PH_FG, PH_SCOLOR, PH_RAW: begin
               shift_in    = pix_done ? '0 : shift_new;
               byte_idx_in = pix_done ? '0 : byte_idx_ff + 1'b1;
               if (pix_done) begin
                  unique case (phase_ff)
                     PH_BG: begin
                        background_in = shift_new;
                        res.color     = shift_new;
                        hdr           = header_phase(flags_ff, STAGE_FG);
                        if (hdr == PH_IDLE) begin
                           res_valid = 1'b1;
                           do_finish = 1'b1;
                        end else begin
                           phase_in = hdr;
                        end
                     end
                     PH_FG: begin
                        foreground_in = shift_new;
                        hdr           = header_phase(flags_ff, STAGE_NSUB);
                        if (hdr == PH_IDLE) begin
                           res_valid = 1'b1;
                           do_finish = 1'b1;
                        end else begin
                           phase_in = hdr;
                        end
                     end
                     PH_SCOLOR: begin
                        foreground_in = shift_new;
                        phase_in      = PH_SXY;
                     end
                     default: begin
                        // raw pixel: write it, then advance column and row
                        res_valid       = 1'b1;
                        res.kind        = hxt_pkg::KIND_PIXEL;
                        res.pos_x       = tile_x + 16'(raw_col_ff);
                        res.pos_y       = tile_y + 16'(raw_row_ff);
                        res.fill_width  = 5'd1;
                        res.fill_height = 5'd1;
                        res.color       = shift_new;
                        if (({1'b0, raw_col_ff} + 5'd1) < tile_w_ff) begin
                           raw_col_in = raw_col_ff + 4'd1;
                        end else begin
                           raw_col_in = '0;
                           if (({1'b0, raw_row_ff} + 5'd1) < tile_h_ff) begin
                              raw_row_in = raw_row_ff + 4'd1;
                           end else begin
                              raw_row_in = '0;
                              do_finish  = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
            PH_NSUB: begin
               subrects_in = item.data_byte;
               res_valid   = 1'b1;
               if (item.data_byte == 8'd0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = flags_ff[hxt_pkg::FLAG_SCOLOR] ? PH_SCOLOR : PH_SXY;
               end
            end
            PH_SXY: begin
               subrect_pos_in = item.data_byte;
               phase_in       = PH_SWH;
            end
            PH_SWH: begin
               res_valid       = 1'b1;
               res.pos_x       = tile_x + 16'(subrect_pos_ff[7:4]);
               res.pos_y       = tile_y + 16'(subrect_pos_ff[3:0]);
               res.fill_width  = 5'(item.data_byte[7:4]) + 5'd1;
               res.fill_height = 5'(item.data_byte[3:0]) + 5'd1;
               res.color       = foreground_ff;
               subrects_in     = subrects_ff - 8'd1;
               if (subrects_ff == 8'd1) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = flags_ff[hxt_pkg::FLAG_SCOLOR] ? PH_SCOLOR : PH_SXY;
               end
            end
            PH_IDLE: begin
               // drop stray bytes
            end
            default: begin
            end
         endcase

         // tile complete: step right, then down, else close the rectangle
         if (do_finish) begin
            if (more_cols) begin
               off_x_in  = next_off_x;
               tile_w_in = tile_span(rect_w_ff, next_off_x);
               phase_in  = PH_SUBENC;
            end else if (more_rows) begin
               off_x_in  = '0;
               off_y_in  = next_off_y;
               tile_w_in = tile_span(rect_w_ff, 16'd0);
               tile_h_in = tile_span(rect_h_ff, next_off_y);
               phase_in  = PH_SUBENC;
            end else begin
               res.rect_done = 1'b1;
               phase_in      = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         background_ff <= '0;
         foreground_ff <= '0;
         shift_ff      <= '0;
         byte_idx_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         background_ff <= background_in;
         foreground_ff <= foreground_in;
         shift_ff      <= shift_in;
         byte_idx_ff   <= byte_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         rect_w_ff      <= rect_w_in;
         rect_h_ff      <= rect_h_in;
         off_x_ff       <= off_x_in;
         off_y_ff       <= off_y_in;
         tile_w_ff      <= tile_w_in;
         tile_h_ff      <= tile_h_in;
         flags_ff       <= flags_in;
         subrects_ff    <= subrects_in;
         subrect_pos_ff <= subrect_pos_in;
         raw_col_ff     <= raw_col_in;
         raw_row_ff     <= raw_row_in;
      end
   end

endmodule

FILE: hdl/hxt_out_stage.sv
// Result register stage: holds one result transaction until the receiver takes it.
module hxt_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             res_valid,
   input  hxt_pkg::rsp_type res,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hxt_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   hxt_pkg::rsp_type data_ff;
   logic             load;

   assign free      = !valid_ff || rsp_ready;
   assign load      = step && res_valid;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

endmodule

FILE: hdl/hextile_tile_decoder.sv
// Hextile rectangle decoder: start and byte transactions in, fill and pixel transactions out.
//
// req_data carries either a rectangle start (opcode start) or one byte of the hextile
// stream (opcode byte). Each transaction produces at most one result on rsp_data: a
// solid fill of up to 16x16 pixels or a single raw pixel write. rect_done marks the
// last result of a rectangle; an empty rectangle produces no results at all.
//
// An accepted item sits in the input register and passes through the parser into the
// result register once the result slot is free. Throughput is one transaction per
// clock while the receiver does not stall, limited by the single parser state update
// per byte. A start received mid-rectangle abandons the current one.
//
// Reset clears both register stages and the parser, and the background and
// foreground colours return to zero. When the receiver stalls, the result register
// holds, the parser stops, and an empty input register still takes one more
// transaction before req_ready falls.
module hextile_tile_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hxt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hxt_pkg::rsp_type rsp_data
);

   logic             item_valid;
   hxt_pkg::req_type item;
   logic             out_free;
   logic             step;
   logic             res_valid;
   hxt_pkg::rsp_type res;

   // consume the held item whenever the result slot can take its result
   assign step = item_valid && out_free;

   hxt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   hxt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   hxt_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/hxt_checker.sv
// Port-level checks for the hextile tile decoder, bound to the top level.
module hxt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hxt_pkg::rsp_type rsp_data
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("stages not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == hxt_pkg::KIND_PIXEL |->
         rsp_data.fill_width == 5'd1 && rsp_data.fill_height == 5'd1)
      else $error("raw pixel with size other than one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fill_width != 5'd0 && rsp_data.fill_height != 5'd0 &&
                    rsp_data.fill_width <= 5'd16 && rsp_data.fill_height <= 5'd16)
      else $error("fill size out of range");

   // with the result slot draining, the input side never blocks
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("input blocked with empty result slot");

endmodule

bind hextile_tile_decoder hxt_checker u_hxt_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the hextile tile decoder: random streams, noise, back-pressure.
module testbench;

   localparam int ITEM_TARGET  = 1350;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [3:0] {
      PS_IDLE, PS_SUBENC, PS_BG, PS_FG, PS_NSUB, PS_SCOLOR, PS_SXY, PS_SWH, PS_RAW
   } parse_state_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   hxt_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   hxt_pkg::rsp_type rsp_data;

   hextile_tile_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Decoder state as predicted
   parse_state_type dec_state = PS_IDLE;
   logic [15:0]  dec_org_x = '0, dec_org_y = '0, dec_tile_x = '0, dec_tile_y = '0;
   logic [16:0]  dec_end_x = '0, dec_end_y = '0;
   logic [4:0]   dec_tile_w = '0, dec_tile_h = '0, dec_flags = '0;
   logic [31:0]  dec_bg = '0, dec_fg = '0, dec_pixel = '0;
   int           dec_byte_idx = 0;
   logic [7:0]   dec_subs_left = '0, dec_sub_xy = '0;
   logic [3:0]   dec_col = '0, dec_row = '0;

   hxt_pkg::rsp_type expected_draws[$];
   int      error_count  = 0;
   int      stream_items = 0;
   int      fills_seen   = 0;
   int      pixels_seen  = 0;
   int      rects_seen   = 0;
   bit      source_idle_on = 1'b1;
   bit      sink_idle_on   = 1'b1;
   int      hold_cycles    = 0;

   function automatic hxt_pkg::rsp_type make_draw(input logic kind, input logic [15:0] x, y,
                                                  input logic [4:0] w, h,
                                                  input logic [31:0] color);
      hxt_pkg::rsp_type d;
      d.kind        = kind;
      d.pos_x       = x;
      d.pos_y       = y;
      d.fill_width  = w;
      d.fill_height = h;
      d.color       = color;
      d.rect_done   = 1'b0;
      return d;
   endfunction

   function automatic void tile_enter();
      logic [15:0] off_x, off_y;
      int          rem_x, rem_y;
      off_x = dec_tile_x - dec_org_x;
      off_y = dec_tile_y - dec_org_y;
      rem_x = int'(dec_end_x - dec_org_x) - int'(off_x);
      rem_y = int'(dec_end_y - dec_org_y) - int'(off_y);
      dec_tile_w = (rem_x < hxt_pkg::TILE_SIZE) ? 5'(rem_x) : 5'(hxt_pkg::TILE_SIZE);
      dec_tile_h = (rem_y < hxt_pkg::TILE_SIZE) ? 5'(rem_y) : 5'(hxt_pkg::TILE_SIZE);
      dec_state  = PS_SUBENC;
   endfunction

   // Step to the next tile in row order; returns 1 when the rectangle is finished
   function automatic bit tile_leave();
      logic [15:0] off_x, off_y;
      off_x = dec_tile_x - dec_org_x;
      off_y = dec_tile_y - dec_org_y;
      if (int'(off_x) + hxt_pkg::TILE_SIZE < int'(dec_end_x - dec_org_x)) begin
         dec_tile_x = dec_tile_x + 16'(hxt_pkg::TILE_SIZE);
      end else if (int'(off_y) + hxt_pkg::TILE_SIZE < int'(dec_end_y - dec_org_y)) begin
         dec_tile_x = dec_org_x;
         dec_tile_y = dec_tile_y + 16'(hxt_pkg::TILE_SIZE);
      end else begin
         dec_state = PS_IDLE;
         return 1'b1;
      end
      tile_enter();
      return 1'b0;
   endfunction

   function automatic void pixel_begin(input parse_state_type next);
      dec_state    = next;
      dec_pixel    = '0;
      dec_byte_idx = 0;
   endfunction

   // Gather one pixel byte, little-endian; returns 1 once the pixel is whole
   function automatic bit pixel_in(input logic [7:0] b);
      dec_pixel = dec_pixel | (32'(b) << (8 * dec_byte_idx));
      if (dec_byte_idx + 1 >= hxt_pkg::BYTES_PER_PIXEL) begin
         dec_byte_idx = 0;
         return 1'b1;
      end
      dec_byte_idx++;
      return 1'b0;
   endfunction

   function automatic bit header_next(input int stage, output hxt_pkg::rsp_type d);
      d = '0;
      if (stage <= 0 && dec_flags[hxt_pkg::FLAG_BG]) begin
         pixel_begin(PS_BG);
         return 1'b0;
      end
      if (stage <= 1 && dec_flags[hxt_pkg::FLAG_FG]) begin
         pixel_begin(PS_FG);
         return 1'b0;
      end
      if (stage <= 2 && dec_flags[hxt_pkg::FLAG_NSUB]) begin
         dec_state = PS_NSUB;
         return 1'b0;
      end
      d = make_draw(hxt_pkg::KIND_FILL, dec_tile_x, dec_tile_y, dec_tile_w, dec_tile_h,
                    dec_bg);
      d.rect_done = tile_leave();
      return 1'b1;
   endfunction

   function automatic void subrect_begin();
      if (dec_flags[hxt_pkg::FLAG_SCOLOR]) pixel_begin(PS_SCOLOR);
      else dec_state = PS_SXY;
   endfunction

   // Advance the predicted decoder by one transaction; returns 1 if it draws something
   function automatic bit hextile_predict(input hxt_pkg::req_type r,
                                          output hxt_pkg::rsp_type d);
      logic [7:0] b;
      b = r.data_byte;
      d = '0;
      if (r.opcode == hxt_pkg::OP_START) begin
         dec_org_x  = r.rect_x;
         dec_org_y  = r.rect_y;
         dec_end_x  = {1'b0, r.rect_x} + {1'b0, r.rect_width};
         dec_end_y  = {1'b0, r.rect_y} + {1'b0, r.rect_height};
         dec_tile_x = r.rect_x;
         dec_tile_y = r.rect_y;
         if (r.rect_width == 16'd0 || r.rect_height == 16'd0) dec_state = PS_IDLE;
         else tile_enter();
         return 1'b0;
      end
      case (dec_state)
         PS_SUBENC: begin
            dec_flags = b[4:0];
            if (dec_flags[hxt_pkg::FLAG_RAW]) begin
               dec_col = '0;
               dec_row = '0;
               pixel_begin(PS_RAW);
               return 1'b0;
            end
            return header_next(0, d);
         end
         PS_BG: begin
            if (!pixel_in(b)) return 1'b0;
            dec_bg = dec_pixel;
            return header_next(1, d);
         end
         PS_FG: begin
            if (!pixel_in(b)) return 1'b0;
            dec_fg = dec_pixel;
            return header_next(2, d);
         end
         PS_NSUB: begin
            dec_subs_left = b;
            d = make_draw(hxt_pkg::KIND_FILL, dec_tile_x, dec_tile_y, dec_tile_w, dec_tile_h,
                          dec_bg);
            if (dec_subs_left == 8'd0) d.rect_done = tile_leave();
            else subrect_begin();
            return 1'b1;
         end
         PS_SCOLOR: begin
            if (!pixel_in(b)) return 1'b0;
            dec_fg    = dec_pixel;
            dec_state = PS_SXY;
            return 1'b0;
         end
         PS_SXY: begin
            dec_sub_xy = b;
            dec_state  = PS_SWH;
            return 1'b0;
         end
         PS_SWH: begin
            // subrectangles are not clipped to the tile
            d = make_draw(hxt_pkg::KIND_FILL, dec_tile_x + 16'(dec_sub_xy[7:4]),
                          dec_tile_y + 16'(dec_sub_xy[3:0]),
                          5'(b[7:4]) + 5'd1, 5'(b[3:0]) + 5'd1, dec_fg);
            dec_subs_left = dec_subs_left - 8'd1;
            if (dec_subs_left == 8'd0) d.rect_done = tile_leave();
            else subrect_begin();
            return 1'b1;
         end
         PS_RAW: begin
            if (!pixel_in(b)) return 1'b0;
            d = make_draw(hxt_pkg::KIND_PIXEL, dec_tile_x + 16'(dec_col),
                          dec_tile_y + 16'(dec_row), 5'd1, 5'd1, dec_pixel);
            dec_pixel = '0;
            if (int'(dec_col) + 1 < int'(dec_tile_w)) begin
               dec_col = dec_col + 4'd1;
            end else begin
               dec_col = '0;
               if (int'(dec_row) + 1 < int'(dec_tile_h)) begin
                  dec_row = dec_row + 4'd1;
               end else begin
                  dec_row = '0;
                  d.rect_done = tile_leave();
               end
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Valid stays high across back-to-back transactions; it only drops for a gap
   task automatic send_item(input hxt_pkg::req_type r);
      int               gap;
      hxt_pkg::rsp_type d;
      gap = source_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (r.opcode == hxt_pkg::OP_START || dec_state != PS_IDLE) stream_items++;
      if (hextile_predict(r, d)) expected_draws.push_back(d);
   endtask

   task automatic send_byte(input logic [7:0] b);
      hxt_pkg::req_type r;
      r.opcode      = hxt_pkg::OP_BYTE;
      r.rect_x      = 16'($urandom_range(0, 65535));
      r.rect_y      = 16'($urandom_range(0, 65535));
      r.rect_width  = 16'($urandom_range(0, 65535));
      r.rect_height = 16'($urandom_range(0, 65535));
      r.data_byte   = b;
      send_item(r);
   endtask

   task automatic send_start(input logic [15:0] x, y, w, h);
      hxt_pkg::req_type r;
      r.opcode      = hxt_pkg::OP_START;
      r.rect_x      = x;
      r.rect_y      = y;
      r.rect_width  = w;
      r.rect_height = h;
      r.data_byte   = 8'($urandom_range(0, 255));
      send_item(r);
   endtask

   task automatic send_pixel(input logic [31:0] color);
      for (int i = 0; i < hxt_pkg::BYTES_PER_PIXEL; i++) send_byte(color[8*i +: 8]);
   endtask

   task automatic send_tile(input int tw, input int th);
      logic [7:0] subenc;
      int         nsub;
      subenc = 8'($urandom_range(0, 255));
      // raw tiles cost a pixel per position; keep them to small tiles
      if (tw * th > 32) subenc[hxt_pkg::FLAG_RAW] = 1'b0;
      send_byte(subenc);
      if (subenc[hxt_pkg::FLAG_RAW]) begin
         repeat (tw * th) send_pixel($urandom);
      end else begin
         if (subenc[hxt_pkg::FLAG_BG]) send_pixel($urandom);
         if (subenc[hxt_pkg::FLAG_FG]) send_pixel($urandom);
         if (subenc[hxt_pkg::FLAG_NSUB]) begin
            nsub = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
            send_byte(8'(nsub));
            repeat (nsub) begin
               if (subenc[hxt_pkg::FLAG_SCOLOR]) send_pixel($urandom);
               send_byte(8'($urandom_range(0, 255)));
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Send a start and well-formed tiles; stop early after max_tiles to leave it abandoned
   task automatic send_rect(input logic [15:0] x, y, w, h, input int max_tiles);
      int tiles;
      int wi, hi;
      wi    = int'(w);
      hi    = int'(h);
      tiles = 0;
      send_start(x, y, w, h);
      for (int oy = 0; oy < hi; oy += hxt_pkg::TILE_SIZE) begin
         for (int ox = 0; ox < wi; ox += hxt_pkg::TILE_SIZE) begin
            if (tiles == max_tiles) return;
            send_tile((wi - ox < hxt_pkg::TILE_SIZE) ? wi - ox : hxt_pkg::TILE_SIZE,
                      (hi - oy < hxt_pkg::TILE_SIZE) ? hi - oy : hxt_pkg::TILE_SIZE);
            tiles++;
         end
      end
   endtask

   function automatic logic [15:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return 16'($urandom_range(65500, 65535));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] rect_extent();
      if ($urandom_range(0, 9) == 0) return 16'($urandom_range(41, 64));
      return 16'($urandom_range(1, 40));
   endfunction

   task automatic test_idle_and_empty();
      send_byte(8'hFF);
      send_start(16'h0000, 16'h0000, 16'd0, 16'd5);
      send_start(16'hFFFF, 16'hFFFF, 16'd5, 16'd0);
   endtask

   task automatic test_restart();
      send_start(16'h0010, 16'h0020, 16'hFFFF, 16'hFFFF);
      send_byte(8'h02);
      send_byte(8'hAB);
   endtask

   task automatic test_raw_wrap();
      // pixel columns wrap from the right edge of the coordinate space to zero
      send_start(16'hFFFF, 16'hFFFF, 16'd2, 16'd1);
      send_byte(8'hFF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
   endtask

   task automatic test_tile_header();
      send_start(16'h8000, 16'h0001, 16'd17, 16'd1);
      send_byte(8'h08);
      send_byte(8'h00);
      send_byte(8'h18);
      send_byte(8'h01);
      send_pixel(32'h8000_0001);
      send_byte(8'hFF);
      send_byte(8'hFF);
   endtask

   task automatic test_backpressure();
      source_idle_on = 1'b0;
      sink_idle_on   = 1'b0;
      hold_cycles    = 300;
      send_start(16'h1234, 16'h0040, 16'd4, 16'd4);
      send_byte(8'h01);
      repeat (16) send_pixel($urandom);
   endtask

   task automatic test_random_streams();
      int pick;
      while (stream_items < ITEM_TARGET) begin
         source_idle_on = ($urandom_range(0, 3) != 0);
         sink_idle_on   = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            send_rect(rand_coord(), rand_coord(), rect_extent(), rect_extent(), 1000);
         end else if (pick < 17) begin
            send_rect(rand_coord(), rand_coord(), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), $urandom_range(0, 2));
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 18) begin
            if ($urandom_range(0, 1)) begin
               send_start(rand_coord(), rand_coord(), 16'd0, 16'($urandom));
            end else begin
               send_start(rand_coord(), rand_coord(), 16'($urandom), 16'd0);
            end
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : result_sink
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = sink_idle_on ? $urandom_range(0, 8) : 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : draw_check
      hxt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_draws.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_draws.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            check_field("pos_x", 32'(want.pos_x), 32'(rsp_data.pos_x));
            check_field("pos_y", 32'(want.pos_y), 32'(rsp_data.pos_y));
            check_field("fill_width", 32'(want.fill_width), 32'(rsp_data.fill_width));
            check_field("fill_height", 32'(want.fill_height), 32'(rsp_data.fill_height));
            check_field("color", want.color, rsp_data.color);
            check_field("rect_done", 32'(want.rect_done), 32'(rsp_data.rect_done));
            if (want.kind == hxt_pkg::KIND_FILL) fills_seen++;
            else pixels_seen++;
            if (want.rect_done) rects_seen++;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_empty();
      test_restart();
      test_raw_wrap();
      test_tile_header();
      test_backpressure();
      test_random_streams();
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Decoded %0d stream transactions under random gaps and a long receiver stall",
               stream_items);
      $display("Checked %0d fills and %0d pixel writes over %0d closed rectangles",
               fills_seen, pixels_seen, rects_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hdl/hxt_pkg.sv
hdl/hxt_in_stage.sv
hdl/hxt_core.sv
hdl/hxt_out_stage.sv
hdl/hextile_tile_decoder.sv
hdl/hxt_checker.sv
sim/testbench.sv
